/* rtl/secb_pkg.sv */
// ----------------------------------------------------------------------------
// secb_pkg
// Shared types and codes for the sorted edge to CSR builder: transaction
// payloads, command and status codes, configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package secb_pkg;

    // Default width of the row id fields that take part in the build
    localparam int ROW_ID_WIDTH_DEF = 64;

    // Width of the offset/position fields of a write command
    localparam int POS_WIDTH = 63;

    // Configuration register indexes
    localparam logic CFG_TRACKING = 1'b0;
    localparam logic CFG_EDGE_IDS = 1'b1;

    // Input command
    typedef enum logic {
        CMD_EDGE   = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    // Result status
    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_APPENDED = 3'd1,
        ST_INVALID  = 3'd2,
        ST_CLOSED   = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // One input item
    typedef struct packed {
        t_cmd               cmd;
        logic signed [63:0] source_row;
        logic signed [63:0] dest_row;
        logic signed [63:0] edge_id;
    } t_in_item;

    // One write command
    typedef struct packed {
        t_status                status;
        logic [POS_WIDTH-1:0]   fill_start;
        logic [POS_WIDTH-1:0]   fill_count;
        logic [POS_WIDTH-1:0]   fill_value;
        logic [POS_WIDTH-1:0]   entry_pos;
        logic [POS_WIDTH-1:0]   entry_dest;
        logic signed [63:0]     entry_edge;
        logic                   entry_edge_valid;
    } t_result;

endpackage

`default_nettype wire

/* rtl/secb_if.sv */
// ----------------------------------------------------------------------------
// secb_in_if / secb_out_if
// Valid/ready channels carrying edge items in and CSR write commands out.
// ----------------------------------------------------------------------------
`default_nettype none

interface secb_in_if;
    logic               valid;
    logic               ready;
    secb_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface secb_out_if;
    logic              valid;
    logic              ready;
    secb_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/secb_skid.sv */
// ----------------------------------------------------------------------------
// secb_skid
// Output register with one skid entry: keeps the upstream ready registered
// and lets one more transaction in while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module secb_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire secb_pkg::t_result i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output secb_pkg::t_result      o_data
);

    logic              r_out_v, n_out_v;
    logic              r_skid_v, n_skid_v;
    secb_pkg::t_result r_out, n_out;
    secb_pkg::t_result r_skid, n_skid;
    logic              w_in_take;
    logic              w_out_free;

    assign o_ready    = !r_skid_v;
    assign w_in_take  = i_valid && !r_skid_v;
    assign w_out_free = !r_out_v || i_ready;

    // next state: skid drains first, new transaction goes to output or skid
    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (w_out_free) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out    = i_data;
                n_out_v  = w_in_take;
            end
        end else if (w_in_take) begin
            n_skid   = i_data;
            n_skid_v = 1'b1;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

/* rtl/sorted_edge_to_csr_builder.sv */
// ----------------------------------------------------------------------------
// sorted_edge_to_csr_builder
// Streaming COO to CSR metadata builder for edges sorted by source row.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries one edge (cmd = edge) or a finish command per transaction.
//   o_out carries one CSR write command per input transaction: an offset
//         fill run (start, count, value) plus the index entry.
//   i_cfg_we/i_cfg_idx/i_cfg_data write tracking_enabled (index 0) and
//   has_edge_ids (index 1); write only while the block is idle.
// Throughput: one transaction per cycle while i_in.ready is high. Build state
//   (current source, entry count, flags) is updated in the accept cycle by a
//   compare, a subtract and one increment, so the next edge can follow at once.
// Output: each result is registered into the output register or the skid entry.
// Stall: an output register plus one skid entry; i_in.ready is registered
//   and drops only when both hold results the receiver has not taken.
// Reset: synchronous, active low. Clears config, build state and both
//   output entries; the block is ready as soon as reset is released.
// A finish command returns the build state to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_edge_to_csr_builder #(
    parameter int ROW_ID_WIDTH = secb_pkg::ROW_ID_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_idx,
    input  wire logic  i_cfg_data,
    secb_in_if.sink    i_in,
    secb_out_if.source o_out
);

    localparam int RW = ROW_ID_WIDTH - 1;   // magnitude bits of a row id
    localparam int PW = secb_pkg::POS_WIDTH;

    // configuration
    logic r_tracking;
    logic r_edge_ids;

    // build state
    logic          r_build_valid, n_build_valid;
    logic          r_build_started, n_build_started;
    logic          r_have_current, n_have_current;
    logic [RW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_ecnt, n_ecnt;

    logic              w_accept;
    logic              w_skid_ready;
    logic              w_src_neg, w_dst_neg;
    logic [RW-1:0]     w_src, w_dst;
    logic [PW-1:0]     w_cur_next;
    logic              w_append;
    secb_pkg::t_result w_res;

    assign w_accept    = i_in.valid && w_skid_ready;
    assign i_in.ready  = w_skid_ready;

    // row ids: low ROW_ID_WIDTH bits, sign at the top
    assign w_src_neg  = i_in.data.source_row[ROW_ID_WIDTH-1];
    assign w_dst_neg  = i_in.data.dest_row[ROW_ID_WIDTH-1];
    assign w_src      = i_in.data.source_row[RW-1:0];
    assign w_dst      = i_in.data.dest_row[RW-1:0];
    assign w_cur_next = PW'(r_cur) + PW'(1);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b0;
            r_edge_ids <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                secb_pkg::CFG_TRACKING: r_tracking <= i_cfg_data;
                secb_pkg::CFG_EDGE_IDS: r_edge_ids <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // one step of the build: result and next state
    always_comb begin
        n_build_valid   = r_build_valid;
        n_build_started = r_build_started;
        n_have_current  = r_have_current;
        n_cur           = r_cur;
        n_ecnt          = r_ecnt;
        w_append        = 1'b0;
        w_res           = '0;
        w_res.status    = secb_pkg::ST_IGNORED;

        if (i_in.data.cmd == secb_pkg::CMD_FINISH) begin
            if (r_build_valid && r_build_started) begin
                w_res.status     = secb_pkg::ST_CLOSED;
                w_res.fill_start = w_cur_next;
                w_res.fill_count = PW'(1);
                w_res.fill_value = r_ecnt;
            end else begin
                w_res.status = secb_pkg::ST_EMPTY;
            end
            n_build_valid   = 1'b1;
            n_build_started = 1'b0;
            n_have_current  = 1'b0;
            n_cur           = '0;
            n_ecnt          = '0;
        end else if (r_tracking && r_build_valid) begin
            n_build_started = 1'b1;
            if (w_src_neg || w_dst_neg) begin
                n_build_valid = 1'b0;
                w_res.status  = secb_pkg::ST_INVALID;
            end else if (!r_have_current) begin
                // first edge: positions 1..source open with value 0
                if (w_src != '0) begin
                    w_res.fill_start = PW'(1);
                    w_res.fill_count = PW'(w_src);
                    w_res.fill_value = r_ecnt;
                end
                n_have_current = 1'b1;
                n_cur          = w_src;
                w_append       = 1'b1;
            end else if (w_src == r_cur) begin
                w_append = 1'b1;
            end else if (w_src < r_cur) begin
                n_build_valid = 1'b0;
                w_res.status  = secb_pkg::ST_INVALID;
            end else begin
                // new larger source: open current+1..source
                w_res.fill_start = w_cur_next;
                w_res.fill_count = PW'(w_src - r_cur);
                w_res.fill_value = r_ecnt;
                n_cur            = w_src;
                w_append         = 1'b1;
            end
        end

        if (w_append) begin
            w_res.status     = secb_pkg::ST_APPENDED;
            w_res.entry_pos  = r_ecnt;
            w_res.entry_dest = PW'(w_dst);
            if (r_edge_ids) begin
                w_res.entry_edge       = i_in.data.edge_id;
                w_res.entry_edge_valid = 1'b1;
            end
            n_ecnt = r_ecnt + PW'(1);
        end
    end

    // build state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build_valid   <= 1'b1;
            r_build_started <= 1'b0;
            r_have_current  <= 1'b0;
            r_cur           <= '0;
            r_ecnt          <= '0;
        end else if (w_accept) begin
            r_build_valid   <= n_build_valid;
            r_build_started <= n_build_started;
            r_have_current  <= n_have_current;
            r_cur           <= n_cur;
            r_ecnt          <= n_ecnt;
        end
    end

    // result register and skid entry
    secb_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_skid_ready),
        .i_data  (w_res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (o_out.data)
    );

    // checks
    a_have_implies_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_current |-> r_build_started)
        else $error("current source held without a started build");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.data.cmd == secb_pkg::CMD_FINISH
        |=> r_build_valid && !r_build_started && !r_have_current && r_ecnt == '0)
        else $error("finish did not clear the build");

    a_count_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_res.status == secb_pkg::ST_APPENDED
        |=> r_ecnt == $past(r_ecnt) + PW'(1))
        else $error("entry count not advanced on append");

    a_ignored_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_res.status == secb_pkg::ST_IGNORED
        |=> $stable(r_ecnt) && $stable(r_cur) && $stable(r_build_valid))
        else $error("ignored transaction changed build state");

endmodule

`default_nettype wire

/* sim/tb_sorted_edge_to_csr_builder.sv */
// ----------------------------------------------------------------------------
// tb_sorted_edge_to_csr_builder
// Self-checking bench for the streaming COO to CSR builder. Edge and finish
// transactions go in on a valid/ready channel. Each accepted transaction is
// run through a local model of the build state, and the write command it
// should produce is queued. Every command taken from the output is compared
// field by field with the oldest queued one. The run covers directed corner
// cases, a long receiver hold-off, and random sorted builds with faults and
// noise under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_sorted_edge_to_csr_builder;
    timeunit 1ns;
    timeprecision 1ps;

    import secb_pkg::*;

    localparam int          ROW_W  = ROW_ID_WIDTH_DEF;
    localparam logic [63:0] MAX63  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN64  = 64'h8000_0000_0000_0000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic i_cfg_data;

    secb_in_if  in_ch ();
    secb_out_if out_ch ();

    sorted_edge_to_csr_builder #(
        .ROW_ID_WIDTH (ROW_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Local copy of configuration and build state
    logic        cfg_track;
    logic        cfg_ids;
    logic        bld_valid;
    logic        bld_started;
    logic        have_src;
    logic [62:0] cur_src;
    logic [62:0] n_entries;

    t_result expected_cmds[$];
    int      n_errors;
    int      gap_pct;
    int      stall_pct;
    int      hold_left;
    int      tracked_sent;

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run limit
    initial begin
        #4_000_000;
        $display("tb_sorted_edge_to_csr_builder: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Build model
    // ------------------------------------------------------------------------
    function automatic logic signed [63:0] row_field(input logic [63:0] raw);
        logic [63:0] t;
        t = raw << (64 - ROW_W);
        return $signed(t) >>> (64 - ROW_W);
    endfunction

    function automatic void clear_build_copy();
        bld_valid   = 1'b1;
        bld_started = 1'b0;
        have_src    = 1'b0;
        cur_src     = '0;
        n_entries   = '0;
    endfunction

    function automatic t_result predict_csr_write(input t_in_item it);
        t_result            r;
        logic signed [63:0] src;
        logic signed [63:0] dst;
        logic [62:0]        usrc;
        r        = '0;
        r.status = ST_IGNORED;

        // Finish closes the offset array and starts a fresh build
        if (it.cmd == CMD_FINISH) begin
            if (bld_valid && bld_started) begin
                r.status     = ST_CLOSED;
                r.fill_start = cur_src + 63'd1;
                r.fill_count = 63'd1;
                r.fill_value = n_entries;
            end else begin
                r.status = ST_EMPTY;
            end
            clear_build_copy();
            return r;
        end

        if (!cfg_track || !bld_valid)
            return r;

        bld_started = 1'b1;
        src = row_field(it.source_row);
        dst = row_field(it.dest_row);

        if (src < 0 || dst < 0) begin
            bld_valid = 1'b0;
            r.status  = ST_INVALID;
            return r;
        end
        usrc = src[62:0];

        // Offset run: rows 1..src on the first edge, cur+1..src on a new row
        if (!have_src) begin
            if (usrc != 0) begin
                r.fill_start = 63'd1;
                r.fill_count = usrc;
                r.fill_value = n_entries;
            end
            have_src = 1'b1;
            cur_src  = usrc;
        end else if (usrc != cur_src) begin
            if (usrc < cur_src) begin
                bld_valid = 1'b0;
                r.status  = ST_INVALID;
                return r;
            end
            r.fill_start = cur_src + 63'd1;
            r.fill_count = usrc - cur_src;
            r.fill_value = n_entries;
            cur_src      = usrc;
        end

        r.status     = ST_APPENDED;
        r.entry_pos  = n_entries;
        r.entry_dest = dst[62:0];
        if (cfg_ids) begin
            r.entry_edge       = it.edge_id;
            r.entry_edge_valid = 1'b1;
        end
        n_entries = n_entries + 63'd1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: queue predictions on input transactions, check output ones
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                expected_cmds.insert(expected_cmds.size(),
                                     predict_csr_write(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_cmds.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected write command, expected none, actual %h",
                             $time, got);
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("fill_start", 64'(want.fill_start), 64'(got.fill_start));
                    check_field("fill_count", 64'(want.fill_count), 64'(got.fill_count));
                    check_field("fill_value", 64'(want.fill_value), 64'(got.fill_value));
                    check_field("entry_pos", 64'(want.entry_pos), 64'(got.entry_pos));
                    check_field("entry_dest", 64'(want.entry_dest), 64'(got.entry_dest));
                    check_field("entry_edge", want.entry_edge, got.entry_edge);
                    check_field("entry_edge_valid", 64'(want.entry_edge_valid),
                                64'(got.entry_edge_valid));
                end
            end
        end
    end

    // Receiver: random stalls, plus a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Driver helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Sends one transaction; returns right after the accepting edge
    task automatic send_item(input t_cmd cmd, input logic [63:0] src,
                             input logic [63:0] dst, input logic [63:0] eid);
        t_in_item it;
        it.cmd        = cmd;
        it.source_row = src;
        it.dest_row   = dst;
        it.edge_id    = eid;
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        forever begin
            @(posedge i_clk);
            if (in_ch.ready)
                break;
        end
        if (cfg_track)
            tracked_sent++;
    endtask

    task automatic send_edge(input logic [63:0] src, input logic [63:0] dst,
                             input logic [63:0] eid);
        send_item(CMD_EDGE, src, dst, eid);
    endtask

    task automatic send_finish();
        send_item(CMD_FINISH, rand64(), rand64(), rand64());
    endtask

    // Drop valid and wait for every queued command, with a bound
    task automatic wait_all_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        while (expected_cmds.size() != 0) begin
            n_errors++;
            $display("%0t: missing write command, expected %h, actual none",
                     $time, expected_cmds[0]);
            void'(expected_cmds.pop_front());
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Register write while idle
    task automatic write_cfg(input logic idx, input logic value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_TRACKING)
            cfg_track = value;
        else
            cfg_ids = value;
    endtask

    task automatic set_config(input logic track, input logic ids);
        wait_all_results();
        write_cfg(CFG_TRACKING, track);
        write_cfg(CFG_EDGE_IDS, ids);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Tracking off: edges ignored, finish on an empty build
    task automatic test_tracking_off();
        set_config(1'b0, 1'b0);
        send_edge(64'd3, 64'd4, 64'd5);
        send_edge(MIN64, 64'hFFFF_FFFF_FFFF_FFFF, MAX63);
        send_finish();
    endtask

    // Offset runs, wrap of the closing offset, invalidation paths
    task automatic test_build_rules();
        set_config(1'b1, 1'b0);
        send_finish();                          // nothing started
        send_edge(64'd0, 64'd7, 64'd0);         // first edge on row 0
        send_edge(64'd0, MAX63, 64'd0);         // same row, largest dest
        send_edge(64'd4, 64'd0, 64'd0);         // skip forward
        send_edge(MAX63, 64'd1, 64'd0);         // largest row
        send_finish();                          // closing offset wraps
        send_edge(64'd3, 64'd1, 64'd0);         // first edge on a later row
        send_edge(64'd2, 64'd1, 64'd0);         // backward source
        send_edge(64'd5, 64'd5, 64'd0);         // ignored while invalid
        send_finish();
        send_edge(MIN64, 64'd0, 64'd0);         // negative source
        send_finish();
        send_edge(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);  // negative dest
        send_finish();
    endtask

    // Edge ids carried; tracking paused mid-build keeps the state
    task automatic test_edge_ids();
        set_config(1'b1, 1'b1);
        send_edge(64'd1, 64'd2, MAX63);
        send_edge(64'd1, 64'd3, MIN64);
        send_edge(64'd2, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        set_config(1'b0, 1'b1);
        send_edge(64'd9, 64'd9, 64'd9);
        set_config(1'b1, 1'b1);
        send_edge(64'd3, 64'd4, 64'd0);
        send_finish();
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        int i;
        set_config(1'b1, 1'b1);
        gap_pct   = 0;
        stall_pct = 0;
        hold_left = 80;
        for (i = 0; i < 30; i++)
            send_edge(64'(i / 3), 64'($urandom_range(0, 100)), rand64());
        send_finish();
        wait_all_results();
    endtask

    // One sorted build with random content; sometimes faulty or unfinished
    task automatic send_random_build();
        int          len;
        int          kind;
        int          fault_at;
        int          i;
        int          r;
        logic [63:0] src;
        logic [63:0] dst;
        logic [63:0] step;
        len      = $urandom_range(1, 24);
        kind     = $urandom_range(99);
        fault_at = $urandom_range(0, len - 1);
        r        = $urandom_range(99);
        if (r < 60)
            src = 64'($urandom_range(0, 20));
        else if (r < 85)
            src = 64'($urandom_range(0, 5000));
        else
            src = MAX63 - 64'($urandom_range(0, 50));

        // Noise: fully random transactions
        if (kind >= 94) begin
            repeat ($urandom_range(1, 3))
                send_item(t_cmd'($urandom_range(0, 1)), rand64(), rand64(), rand64());
            return;
        end

        for (i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 70)
                dst = 64'($urandom_range(0, 1000));
            else
                dst = rand64() & MAX63;
            if (kind < 12 && i == fault_at) begin
                case ($urandom_range(0, 2))
                    0: send_edge(rand64() | MIN64, dst, rand64());
                    1: send_edge(src, rand64() | MIN64, rand64());
                    default: begin
                        if (src == 0)
                            send_edge(rand64() | MIN64, dst, rand64());
                        else
                            send_edge(src - 64'($urandom_range(1, 3)) % src - 1
                                      + 64'd1 - 64'd1, dst, rand64());
                    end
                endcase
            end else begin
                send_edge(src, dst, rand64());
            end

            // Advance the source row, saturating at the largest value
            r = $urandom_range(99);
            if (r < 40)
                step = '0;
            else if (r < 85)
                step = 64'($urandom_range(1, 4));
            else if (r < 95)
                step = 64'($urandom_range(1, 1000));
            else
                step = rand64() & MAX63;
            if (step > MAX63 - src)
                src = MAX63;
            else
                src = src + step;
        end

        // Most builds close; a few leave the build open for the next one
        if (kind < 12 || kind >= 17)
            send_finish();
        if (kind >= 17 && kind < 20)
            send_finish();
    endtask

    task automatic run_random_phase(input int gap, input int stall, input logic track,
                                    input logic ids, input int target);
        set_config(track, ids);
        gap_pct      = gap;
        stall_pct    = stall;
        tracked_sent = 0;
        if (!track) begin
            repeat (target) send_random_build();
        end else begin
            while (tracked_sent < target)
                send_random_build();
            send_finish();
        end
        wait_all_results();
    endtask

    task automatic test_random_builds();
        run_random_phase(0,  0,  1'b1, 1'b0, 175);
        run_random_phase(46, 0,  1'b1, 1'b1, 175);
        run_random_phase(0,  0,  1'b0, 1'b1, 5);
        run_random_phase(0,  46, 1'b1, 1'b1, 175);
        run_random_phase(36, 36, 1'b1, 1'b0, 175);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = 1'b0;
        i_cfg_data   = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        n_errors     = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_left    = 0;
        tracked_sent = 0;
        cfg_track    = 1'b0;
        cfg_ids      = 1'b0;
        clear_build_copy();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_tracking_off();
        test_build_rules();
        test_edge_ids();
        test_backpressure();
        test_random_builds();

        wait_all_results();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_sorted_edge_to_csr_builder: done, clean");
        else
            $display("tb_sorted_edge_to_csr_builder: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/secb_pkg.sv
rtl/secb_if.sv
rtl/secb_skid.sv
rtl/sorted_edge_to_csr_builder.sv
sim/tb_sorted_edge_to_csr_builder.sv
